// File: design/frame_nibble_delta_encoder_assert.svh
// ----------------------------------------------------------------------------
// frame_nibble_delta_encoder_assert.svh
// Assertion macros for the frame nibble delta encoder. They expect signals
// named clk and rst (synchronous, active high) in the including scope.
// ----------------------------------------------------------------------------
`ifndef FRAME_NIBBLE_DELTA_ENCODER_ASSERT_SVH
`define FRAME_NIBBLE_DELTA_ENCODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FNDE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FNDE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/fnde_pkg.sv
// ----------------------------------------------------------------------------
// fnde_pkg
// Shared widths, types and helpers of the frame nibble delta encoder.
// ----------------------------------------------------------------------------
package fnde_pkg;

  localparam int MAX_CHANNELS = 16;
  localparam int CH_W         = $clog2(MAX_CHANNELS);
  localparam int CNT_W        = CH_W + 1;
  localparam int CFG_W        = 5;
  localparam int SAMPLE_W     = 16;
  localparam int BYTE_W       = 8;
  localparam int NIB_W        = 4;
  localparam int NIB_MIN      = -8;
  localparam int NIB_MAX      = 7;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_FIRST_LO,
    ST_MASK_LO,
    ST_MASK_HI,
    ST_NIB,
    ST_ABS_HI,
    ST_ABS_LO
  } fnde_state_t;

  // One byte handed from the sequencer to the output register.
  typedef struct packed {
    logic              load;
    logic              last;
    logic [BYTE_W-1:0] data;
  } fnde_byte_t;

  // Clamp the configured count into 1..MAX_CHANNELS.
  function automatic logic [CNT_W-1:0] active_count(input logic [CFG_W-1:0] cfg);
    logic [CNT_W-1:0] n;
    if (cfg == '0) begin
      n = CNT_W'(1);
    end else if (cfg > CFG_W'(MAX_CHANNELS)) begin
      n = CNT_W'(MAX_CHANNELS);
    end else begin
      n = CNT_W'(cfg);
    end
    return n;
  endfunction

  // One bit per channel below the active count.
  function automatic logic [MAX_CHANNELS-1:0] active_mask(input logic [CNT_W-1:0] n);
    logic [MAX_CHANNELS-1:0] m;
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      m[i] = (CNT_W'(i) < n);
    end
    return m;
  endfunction

endpackage

// File: design/fnde_ifs.sv
// ----------------------------------------------------------------------------
// fnde_ifs
// Valid/ready channels of the frame nibble delta encoder.
// ----------------------------------------------------------------------------
interface fnde_sample_if;
  import fnde_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                start_req;

  modport source (output valid, sample, start_req, input ready);
  modport sink   (input valid, sample, start_req, output ready);
endinterface

interface fnde_stream_if;
  import fnde_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_out;
  logic              last;

  modport source (output valid, byte_out, last, input ready);
  modport sink   (input valid, byte_out, last, output ready);
endinterface

// File: design/fnde_obuf.sv
// ----------------------------------------------------------------------------
// fnde_obuf
// Output register of the encoded byte stream; decouples the sequencer from
// the downstream ready.
// ----------------------------------------------------------------------------
module fnde_obuf (
  input  logic                clk,
  input  logic                rst,
  input  fnde_pkg::fnde_byte_t ld,
  output logic                room,
  fnde_stream_if.source       stream
);
  import fnde_pkg::*;

  logic              valid;
  logic [BYTE_W-1:0] data;
  logic              last;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ld.load) begin
      valid <= 1'b1;
    end else if (stream.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.load) begin
      data <= ld.data;
      last <= ld.last;
    end
  end

  assign room            = !valid || stream.ready;
  assign stream.valid    = valid;
  assign stream.byte_out = data;
  assign stream.last     = last;

endmodule

// File: design/frame_nibble_delta_encoder.sv
// ----------------------------------------------------------------------------
// frame_nibble_delta_encoder
// Delta encoder for multi-channel 16-bit samples: absolute first frame,
// then per-frame escape mask, packed 4-bit deltas and escaped absolutes.
//
//   channel   dir  handshake     payload
//   samples   in   valid/ready   sample[15:0], start_req
//   stream    out  valid/ready   byte_out[7:0], last
//   cfg       in   cfg_we        cfg_wdata[4:0] (channels_per_frame)
//
// A first-frame sample passes the read and low-byte states; a delta sample
// that does not close its frame passes only the read state (for the
// previous-value memory read). A closing one goes on through the mask bytes,
// the nibble bytes, a scan up to the last escaped channel and its absolutes;
// bytes leave one per cycle through the output register while ready is high.
// Reset clears control state only; the value and nibble memories are not
// cleared. A stall on the stream side holds the sequencer in place.
// ----------------------------------------------------------------------------
module frame_nibble_delta_encoder (
  input  logic                       clk,
  input  logic                       rst,
  fnde_sample_if.sink                samples,
  fnde_stream_if.source              stream,
  input  logic                       cfg_we,
  input  logic [fnde_pkg::CFG_W-1:0] cfg_wdata
);
  import fnde_pkg::*;
  `include "frame_nibble_delta_encoder_assert.svh"

  localparam logic signed [SAMPLE_W:0] D_MIN = (SAMPLE_W+1)'(NIB_MIN);
  localparam logic signed [SAMPLE_W:0] D_MAX = (SAMPLE_W+1)'(NIB_MAX);

  logic [CFG_W-1:0]        cfg;
  logic [CNT_W-1:0]        n;
  logic [MAX_CHANNELS-1:0] n_mask;

  fnde_state_t             state, state_next;
  logic [CH_W-1:0]         channel_index, channel_index_next;
  logic                    in_first_frame, in_first_frame_next;
  logic [MAX_CHANNELS-1:0] escape_mask, escape_mask_next;
  logic [MAX_CHANNELS-1:0] frame_mask, frame_mask_next;
  logic [CNT_W-1:0]        ptr, ptr_next;

  logic [SAMPLE_W-1:0]     s_reg;
  logic [CH_W-1:0]         ch_reg;
  logic                    first_reg;

  logic                    accept;
  logic [CH_W-1:0]         acc_ch;

  logic [SAMPLE_W-1:0]     prev_mem [MAX_CHANNELS];
  logic [NIB_W-1:0]        nib_mem  [MAX_CHANNELS];
  logic [CH_W-1:0]         prev_raddr, nib_raddr_a, nib_raddr_b;
  logic [SAMPLE_W-1:0]     prev_rdata;
  logic [NIB_W-1:0]        nib_rdata_a, nib_rdata_b;
  logic                    prev_we, nib_we;
  logic [NIB_W-1:0]        nib_wdata;

  logic signed [SAMPLE_W:0] delta;
  logic                    fits;
  logic                    frame_end;
  logic [MAX_CHANNELS-1:0] ch_bit, mask_upd, abs_rest;
  logic                    nib_tail;
  logic [NIB_W-1:0]        nib_lo;

  fnde_byte_t              ld;
  logic                    room;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      cfg <= cfg_wdata;
    end
  end

  assign n      = active_count(cfg);
  assign n_mask = active_mask(n);

  assign samples.ready = (state == ST_IDLE);
  assign accept        = samples.valid && samples.ready;
  assign acc_ch        = samples.start_req ? '0 : channel_index;

  always_ff @(posedge clk) begin
    if (accept) begin
      s_reg     <= samples.sample;
      ch_reg    <= acc_ch;
      first_reg <= samples.start_req || in_first_frame;
    end
  end

  // Previous values: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[ch_reg] <= s_reg;
    end
    prev_rdata <= prev_mem[prev_raddr];
  end

  // Nibbles: one write port, two registered read ports for a channel pair.
  always_ff @(posedge clk) begin
    if (nib_we) begin
      nib_mem[ch_reg] <= nib_wdata;
    end
    nib_rdata_a <= nib_mem[nib_raddr_a];
    nib_rdata_b <= nib_mem[nib_raddr_b];
  end

  assign delta     = $signed({1'b0, s_reg}) - $signed({1'b0, prev_rdata});
  assign fits      = (delta >= D_MIN) && (delta <= D_MAX);
  assign frame_end = (CNT_W'(ch_reg) + CNT_W'(1)) >= n;
  assign ch_bit    = MAX_CHANNELS'(1) << ch_reg;
  assign mask_upd  = fits ? escape_mask : (escape_mask | ch_bit);
  assign abs_rest  = frame_mask & ~(MAX_CHANNELS'(1) << ptr[CH_W-1:0]);
  assign nib_tail  = (ptr + CNT_W'(2)) >= n;
  assign nib_lo    = ((ptr + CNT_W'(1)) < n) ? nib_rdata_b : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      channel_index  <= '0;
      in_first_frame <= 1'b1;
      escape_mask    <= '0;
      frame_mask     <= '0;
      ptr            <= '0;
    end else begin
      state          <= state_next;
      channel_index  <= channel_index_next;
      in_first_frame <= in_first_frame_next;
      escape_mask    <= escape_mask_next;
      frame_mask     <= frame_mask_next;
      ptr            <= ptr_next;
    end
  end

  always_comb begin
    state_next          = state;
    channel_index_next  = channel_index;
    in_first_frame_next = in_first_frame;
    escape_mask_next    = escape_mask;
    frame_mask_next     = frame_mask;
    ptr_next            = ptr;
    prev_we             = 1'b0;
    nib_we              = 1'b0;
    nib_wdata           = fits ? delta[NIB_W-1:0] : '0;
    ld                  = '0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_READ;
          if (samples.start_req) begin
            escape_mask_next    = '0;
            in_first_frame_next = 1'b1;
          end
        end
      end
      ST_READ: begin
        if (first_reg) begin
          prev_we = 1'b1;
          if (room) begin
            ld         = '{load: 1'b1, last: 1'b0, data: s_reg[SAMPLE_W-1:BYTE_W]};
            state_next = ST_FIRST_LO;
            if (frame_end) begin
              channel_index_next  = '0;
              in_first_frame_next = 1'b0;
            end else begin
              channel_index_next = ch_reg + CH_W'(1);
            end
          end
        end else begin
          prev_we  = 1'b1;
          nib_we   = 1'b1;
          ptr_next = '0;
          if (frame_end) begin
            frame_mask_next    = mask_upd & n_mask;
            escape_mask_next   = '0;
            channel_index_next = '0;
            state_next         = ST_MASK_LO;
          end else begin
            escape_mask_next   = mask_upd;
            channel_index_next = ch_reg + CH_W'(1);
            state_next         = ST_IDLE;
          end
        end
      end
      ST_FIRST_LO: begin
        if (room) begin
          ld         = '{load: 1'b1, last: 1'b1, data: s_reg[BYTE_W-1:0]};
          state_next = ST_IDLE;
        end
      end
      ST_MASK_LO: begin
        if (room) begin
          ld         = '{load: 1'b1, last: 1'b0, data: frame_mask[BYTE_W-1:0]};
          state_next = ST_MASK_HI;
        end
      end
      ST_MASK_HI: begin
        if (room) begin
          ld         = '{load: 1'b1, last: 1'b0,
                         data: frame_mask[MAX_CHANNELS-1:BYTE_W]};
          state_next = ST_NIB;
        end
      end
      ST_NIB: begin
        if (room) begin
          ld = '{load: 1'b1, last: nib_tail && (frame_mask == '0),
                 data: {nib_rdata_a, nib_lo}};
          if (nib_tail) begin
            ptr_next   = '0;
            state_next = (frame_mask == '0) ? ST_IDLE : ST_ABS_HI;
          end else begin
            ptr_next = ptr + CNT_W'(2);
          end
        end
      end
      ST_ABS_HI: begin
        // skip channels that fit; read data is registered from ptr_next, so it matches ptr
        if (frame_mask[ptr[CH_W-1:0]]) begin
          if (room) begin
            ld         = '{load: 1'b1, last: 1'b0,
                           data: prev_rdata[SAMPLE_W-1:BYTE_W]};
            state_next = ST_ABS_LO;
          end
        end else begin
          ptr_next = ptr + CNT_W'(1);
        end
      end
      ST_ABS_LO: begin
        if (room) begin
          ld              = '{load: 1'b1, last: (abs_rest == '0),
                              data: prev_rdata[BYTE_W-1:0]};
          frame_mask_next = abs_rest;
          ptr_next        = ptr + CNT_W'(1);
          state_next      = (abs_rest == '0) ? ST_IDLE : ST_ABS_HI;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    prev_raddr  = (state == ST_IDLE) ? acc_ch : ptr_next[CH_W-1:0];
    nib_raddr_a = ptr_next[CH_W-1:0];
    nib_raddr_b = ptr_next[CH_W-1:0] | CH_W'(1);
  end

  fnde_obuf u_obuf (
    .clk    (clk),
    .rst    (rst),
    .ld     (ld),
    .room   (room),
    .stream (stream)
  );

  `FNDE_ASSERT_NEXT(a_accept_read, accept, state == ST_READ, "accept did not enter read")
  `FNDE_ASSERT_NEXT(a_start_first, accept && samples.start_req, first_reg,
                    "start mark did not open an absolute frame")
  `FNDE_ASSERT_IMPL(a_load_room, ld.load, room, "byte loaded into a full output register")
  `FNDE_ASSERT_IMPL(a_abs_flagged, state == ST_ABS_LO, frame_mask[ptr[CH_W-1:0]],
                    "absolute sent for a channel that is not escaped")
  `FNDE_ASSERT_NEXT(a_mask_cleared, ld.load && ld.last && !first_reg, escape_mask == '0,
                    "escape mask not cleared after delta frame")

endmodule

// File: verif/frame_nibble_delta_encoder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_nibble_delta_encoder_test
// Self-checking bench for the frame nibble delta encoder. Sends directed and
// random sample streams over several channel counts, with random gaps on the
// sample side and random stalls on the byte side. Every accepted sample is
// run through a behavioral copy of the encoder, and each byte that leaves the
// block is compared with the oldest predicted byte.
// ----------------------------------------------------------------------------

class encoded_byte_tracker;
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  logic [15:0]                      prev_val   [fnde_pkg::MAX_CHANNELS];
  bit                               prev_seen  [fnde_pkg::MAX_CHANNELS];
  logic [3:0]                       nib        [fnde_pkg::MAX_CHANNELS];
  logic [fnde_pkg::MAX_CHANNELS-1:0] esc_mask;
  int unsigned                      ch_idx;
  bit                               first_frame;
  logic [fnde_pkg::CFG_W-1:0]       count_reg;
  stream_byte_t                     pending_bytes[$];
  int unsigned                      failures;

  function new();
    foreach (prev_seen[i]) begin
      prev_seen[i] = 1'b0;
      prev_val[i]  = '0;
      nib[i]       = '0;
    end
    esc_mask    = '0;
    ch_idx      = 0;
    first_frame = 1'b1;
    count_reg   = fnde_pkg::CFG_RESET;
    failures    = 0;
  endfunction

  function void set_count(logic [fnde_pkg::CFG_W-1:0] v);
    count_reg = v;
  endfunction

  function int unsigned frame_size();
    if (count_reg == '0) return 1;
    if (count_reg > fnde_pkg::CFG_W'(fnde_pkg::MAX_CHANNELS)) return fnde_pkg::MAX_CHANNELS;
    return count_reg;
  endfunction

  function int unsigned pending();
    return pending_bytes.size();
  endfunction

  function bit in_first_frame();
    return first_frame;
  endfunction

  // A delta sample on a channel never filled in would read an unwritten entry.
  function bit reads_unwritten();
    return !first_frame && !prev_seen[ch_idx % fnde_pkg::MAX_CHANNELS];
  endfunction

  function logic [15:0] channel_value();
    return prev_val[ch_idx % fnde_pkg::MAX_CHANNELS];
  endfunction

  function void take_sample(logic [15:0] s, logic st);
    logic [7:0]  frame_bytes[$];
    logic [15:0] m;
    int unsigned n;
    int unsigned ch;
    int          d;
    stream_byte_t sb;
    n = frame_size();
    if (st) begin
      ch_idx      = 0;
      esc_mask    = '0;
      first_frame = 1'b1;
    end
    ch = ch_idx % fnde_pkg::MAX_CHANNELS;
    if (first_frame) begin
      prev_val[ch]  = s;
      prev_seen[ch] = 1'b1;
      frame_bytes.insert(frame_bytes.size(), s[15:8]);
      frame_bytes.insert(frame_bytes.size(), s[7:0]);
      if (ch + 1 >= n) begin
        ch_idx      = 0;
        first_frame = 1'b0;
      end else begin
        ch_idx = ch + 1;
      end
    end else begin
      d = int'(s) - int'(prev_val[ch]);
      if (d < fnde_pkg::NIB_MIN || d > fnde_pkg::NIB_MAX) begin
        esc_mask[ch] = 1'b1;
        nib[ch]      = '0;
      end else begin
        nib[ch] = d[3:0];
      end
      prev_val[ch] = s;
      if (ch + 1 >= n) begin
        // Drop mask bits of channels at or above the count.
        for (int j = 0; j < 16; j++) m[j] = esc_mask[j] && (j < n);
        frame_bytes.insert(frame_bytes.size(), m[7:0]);
        frame_bytes.insert(frame_bytes.size(), m[15:8]);
        for (int j = 0; j < n; j += 2) begin
          frame_bytes.insert(frame_bytes.size(), {nib[j], (j + 1 < n) ? nib[j+1] : 4'h0});
        end
        for (int j = 0; j < n; j++) begin
          if (m[j]) begin
            frame_bytes.insert(frame_bytes.size(), prev_val[j][15:8]);
            frame_bytes.insert(frame_bytes.size(), prev_val[j][7:0]);
          end
        end
        esc_mask = '0;
        ch_idx   = 0;
      end else begin
        ch_idx = ch + 1;
      end
    end
    foreach (frame_bytes[i]) begin
      sb.data = frame_bytes[i];
      sb.last = (i == frame_bytes.size() - 1);
      pending_bytes.insert(pending_bytes.size(), sb);
    end
  endfunction

  function void take_byte(logic [7:0] data, logic last);
    stream_byte_t want;
    if (pending_bytes.size() == 0) begin
      $error("byte_out: no byte expected, got %02h (last %0b)", data, last);
      failures++;
      return;
    end
    want = pending_bytes.pop_front();
    if (data !== want.data) begin
      $error("byte_out: expected %02h, got %02h", want.data, data);
      failures++;
    end
    if (last !== want.last) begin
      $error("last: expected %0b, got %0b", want.last, last);
      failures++;
    end
  endfunction
endclass

module frame_nibble_delta_encoder_test;
  import fnde_pkg::*;

  localparam int RANDOM_ITEMS   = 420;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 60;
  localparam int WATCHDOG_LIMIT = 2000;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  fnde_sample_if samples_if();
  fnde_stream_if stream_if();

  encoded_byte_tracker tracker = new();

  bit          tx_gaps   = 1'b1;
  bit          rx_stalls = 1'b1;
  int unsigned quiet_cycles;

  logic [CFG_W-1:0] count_plan [12] = '{5'd31, 5'd16, 5'd1, 5'd17, 5'd7, 5'd0,
                                        5'd15, 5'd2, 5'd16, 5'd5, 5'd9, 5'd31};

  frame_nibble_delta_encoder u_dut (
    .clk      (clk),
    .rst      (rst),
    .samples  (samples_if),
    .stream   (stream_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Check output bytes and watch for a hung handshake.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (stream_if.valid && stream_if.ready) begin
        tracker.take_byte(stream_if.byte_out, stream_if.last);
      end
      if ((stream_if.valid && stream_if.ready) || (samples_if.valid && samples_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT - 1) begin
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Byte side: bursts of ready, mostly short stalls, a few long ones.
  initial begin
    int unsigned run;
    stream_if.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (!rx_stalls) begin
        stream_if.ready <= 1'b1;
        @(posedge clk);
      end else begin
        stream_if.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        stream_if.ready <= 1'b0;
        run = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        repeat (run) @(posedge clk);
      end
    end
  end

  function automatic int unsigned gap_len();
    int unsigned pick;
    if (!tx_gaps) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_item(input logic [15:0] s, input logic st);
    int unsigned gap;
    gap = gap_len();
    if (gap != 0) begin
      samples_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples_if.valid     <= 1'b1;
    samples_if.sample    <= s;
    samples_if.start_req <= st;
    do @(posedge clk); while (!samples_if.ready);
    tracker.take_sample(s, st);
  endtask

  // Hold the sample side until every predicted byte is out.
  task automatic wait_for_drain();
    samples_if.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input logic [CFG_W-1:0] v);
    wait_for_drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_count(v);
  endtask

  initial begin
    int unsigned sent;
    int unsigned phase;
    int unsigned burst;
    int unsigned pick;
    int          step;
    logic [15:0] s;
    logic        st;

    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_wdata            <= CFG_RESET;
    samples_if.valid     <= 1'b0;
    samples_if.sample    <= '0;
    samples_if.start_req <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Four channels: absolute frame, then deltas at both nibble limits and
    // just past them.
    write_count(5'd4);
    send_item(16'h0010, 1'b1);
    send_item(16'hFFF0, 1'b0);
    send_item(16'h8000, 1'b0);
    send_item(16'h7FFF, 1'b0);
    send_item(16'h0008, 1'b0);
    send_item(16'hFFF7, 1'b0);
    send_item(16'h7FF7, 1'b0);
    send_item(16'h8007, 1'b0);
    send_item(16'h0000, 1'b0);
    send_item(16'hFFFF, 1'b0);
    send_item(16'h7FF7, 1'b0);
    send_item(16'h0000, 1'b0);

    // Odd channel count pads the nibble tail.
    write_count(5'd3);
    send_item(16'h1234, 1'b1);
    send_item(16'hABCD, 1'b0);
    send_item(16'h00FF, 1'b0);
    send_item(16'h1233, 1'b0);
    send_item(16'hABCD, 1'b0);
    send_item(16'h0100, 1'b0);

    // Lower the count mid-frame: the next sample closes the frame.
    send_item(16'h1230, 1'b0);
    send_item(16'hFFFF, 1'b0);
    write_count(5'd1);
    send_item(16'h0107, 1'b0);

    // A zero count acts as one channel.
    write_count(5'd0);
    send_item(16'h1228, 1'b0);

    // Start mark in the middle of a delta frame.
    write_count(5'd2);
    send_item(16'h1229, 1'b0);
    send_item(16'h5555, 1'b1);
    send_item(16'hAAAA, 1'b0);

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      write_count(phase < 12 ? count_plan[phase] : CFG_W'($urandom_range(0, 31)));
      case ($urandom_range(0, 3))
        0: begin tx_gaps = 1'b0; rx_stalls = 1'b0; end
        1: begin tx_gaps = 1'b1; rx_stalls = 1'b1; end
        2: begin tx_gaps = 1'b1; rx_stalls = 1'b0; end
        default: begin tx_gaps = 1'b0; rx_stalls = 1'b1; end
      endcase
      burst = $urandom_range(12, 48);
      for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        st = ($urandom_range(0, 99) < 4);
        // Restart the stream rather than read a channel never filled in.
        if (!st && tracker.reads_unwritten()) st = 1'b1;
        pick = $urandom_range(0, 99);
        if (st || tracker.in_first_frame() || pick >= 85) begin
          s = 16'($urandom_range(0, 65535));
        end else begin
          if (pick < 70) begin
            step = int'($urandom_range(0, 15)) - 8;
          end else begin
            case ($urandom_range(0, 3))
              0: step = -9;
              1: step = 8;
              2: step = -8;
              default: step = 7;
            endcase
          end
          s = tracker.channel_value() + 16'(step);
        end
        send_item(s, st);
        sent++;
        if ($urandom_range(0, 99) < 3) wait_for_drain();
      end
      phase++;
    end

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
